@@ rtl/uvs_pkg.sv @@
// Shared types, constants and CORDIC angle table for the UV sphere mesh generator.
`default_nettype none
package uvs_pkg;

   localparam logic [1:0] KIND_VERTEX   = 2'd0;
   localparam logic [1:0] KIND_TRIANGLE = 2'd1;
   localparam logic [1:0] KIND_REJECT   = 2'd2;

   localparam logic [1:0] CSR_SLICE_COUNT = 2'd0;
   localparam logic [1:0] CSR_STACK_COUNT = 2'd1;
   localparam logic [1:0] CSR_DIAMETER    = 2'd2;

   localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

   typedef struct packed {
      logic       action;
      logic [8:0] ring;
      logic [7:0] segment;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [15:0]        vertex_number;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [15:0]        corner_a;
      logic [15:0]        corner_b;
      logic [15:0]        corner_c;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic        vld;
      logic        action;
      logic        ok;
      logic [1:0]  pole;
      logic [8:0]  ring;
      logic [7:0]  segment;
      logic [8:0]  slices;
      logic [8:0]  stacks;
      logic [15:0] diam;
   } ctl_type;

   function automatic logic signed [33:0] atan_turn(input int i);
      logic signed [33:0] t;
      case (i)
         0: t = 34'sh20000000;   1: t = 34'sh12E4051E;
         2: t = 34'sh09FB385B;   3: t = 34'sh051111D4;
         4: t = 34'sh028B0D43;   5: t = 34'sh0145D7E1;
         6: t = 34'sh00A2F61E;   7: t = 34'sh00517C55;
         8: t = 34'sh0028BE53;   9: t = 34'sh00145F2F;
         10: t = 34'sh000A2F98;  11: t = 34'sh000517CC;
         12: t = 34'sh00028BE6;  13: t = 34'sh000145F3;
         14: t = 34'sh0000A2F9;  15: t = 34'sh0000517D;
         16: t = 34'sh000028BE;  17: t = 34'sh0000145F;
         18: t = 34'sh00000A30;  19: t = 34'sh00000518;
         20: t = 34'sh0000028C;  21: t = 34'sh00000146;
         22: t = 34'sh000000A3;  23: t = 34'sh00000051;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

@@ rtl/uv_sphere_mesh_generator.sv @@
// Path: divider and CORDIC pipelines, then stages A and B, then the output register.
// Throughput: one request per cycle while the output is not stalled; band cells
// produce two response beats, so the request side stalls while the second is held.
// All stages advance together; these pipelines and stages set the latency.
// Reset: synchronous; registers return to 16 slices, 16 stacks, diameter 512.
`default_nettype none
module uv_sphere_mesh_generator
   import uvs_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   localparam int DIV_LAT = 33;
   localparam int CRD_LAT = ANGLE_ITERATIONS + 1;
   localparam int DEPTH   = DIV_LAT + CRD_LAT;

   logic [8:0]  slices_ff, stacks_ff;
   logic [15:0] diam_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         slices_ff <= 9'd16;
         stacks_ff <= 9'd16;
         diam_ff   <= 16'd512;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SLICE_COUNT: slices_ff <= csr_data[8:0];
            CSR_STACK_COUNT: stacks_ff <= csr_data[8:0];
            CSR_DIAMETER:    diam_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline advance: whole pipe moves when the output stage can take a beat.
   logic adv;
   logic out_busy;

   ctl_type ctl_in;
   ctl_type ctl_ff [DEPTH];
   logic    cfg_ok;
   assign cfg_ok = slices_ff >= 9'd3 && slices_ff <= 9'd256 && stacks_ff >= 9'd2
                   && stacks_ff <= 9'd256;

   always_comb begin
      ctl_in = '0;
      ctl_in.vld     = req_valid && req_ready;
      ctl_in.action  = req_data.action;
      ctl_in.ring    = req_data.ring;
      ctl_in.segment = req_data.segment;
      ctl_in.slices  = slices_ff;
      ctl_in.stacks  = stacks_ff;
      ctl_in.diam    = diam_ff;
      ctl_in.pole    = {req_data.ring == stacks_ff, req_data.ring == 9'd0};
      if (!req_data.action)
         ctl_in.ok = cfg_ok && req_data.ring <= stacks_ff &&
                     (req_data.ring == 9'd0 || req_data.ring == stacks_ff ||
                      {1'b0, req_data.segment} < slices_ff);
      else
         ctl_in.ok = cfg_ok && req_data.ring < stacks_ff &&
                     {1'b0, req_data.segment} < slices_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) ctl_ff[k].vld <= 1'b0;
      end else if (adv) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < DEPTH; k++) ctl_ff[k] <= ctl_ff[k-1];
      end
   end

   logic [31:0] phi_q, th_q;
   uvs_divider u_div_phi (.clock(clock), .adv(adv), .num(req_data.ring),
                          .den(stacks_ff), .quo(phi_q));
   uvs_divider u_div_th (.clock(clock), .adv(adv), .num({1'b0, req_data.segment}),
                         .den(slices_ff), .quo(th_q));

   // phi = ring*2^31/stacks = half of the 2^32 quotient
   logic signed [33:0] sp, cp, st, ct;
   uvs_cordic #(.ITER(ANGLE_ITERATIONS)) u_crd_phi (.clock(clock), .adv(adv),
      .angle({1'b0, phi_q[31:1]}), .sin_o(sp), .cos_o(cp));
   uvs_cordic #(.ITER(ANGLE_ITERATIONS)) u_crd_th (.clock(clock), .adv(adv),
      .angle(th_q), .sin_o(st), .cos_o(ct));

   // Stage A: pole override and products
   ctl_type a_ff;
   logic signed [67:0] px_ff, pz_ff;
   logic signed [33:0] ty_a_ff;
   logic [15:0] num_a_ff, base_a_ff;
   ctl_type c;
   assign c = ctl_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) a_ff.vld <= 1'b0;
      else if (adv) a_ff.vld <= c.vld;
      if (adv) begin
         a_ff.action <= c.action; a_ff.ok <= c.ok; a_ff.pole <= c.pole;
         a_ff.ring <= c.ring; a_ff.segment <= c.segment; a_ff.slices <= c.slices;
         a_ff.stacks <= c.stacks; a_ff.diam <= c.diam;
         if (c.pole != 2'b00) begin
            px_ff <= '0; pz_ff <= '0;
            ty_a_ff <= c.pole[0] ? ONE_Q30 : -ONE_Q30;
         end else begin
            px_ff <= sp * ct; pz_ff <= sp * st; ty_a_ff <= cp;
         end
         num_a_ff  <= 16'(({7'd0, c.ring} - 16'd1) * {7'd0, c.slices});
         base_a_ff <= 16'({7'd0, c.slices} * ({7'd0, c.stacks} - 16'd2));
      end
   end

   // Stage B: round products, vertex number, triangle corner bases
   ctl_type b_ff;
   logic signed [33:0] tx_b_ff, ty_b_ff, tz_b_ff;
   logic [15:0] num_b_ff, bb_ff, i0_ff, i1_ff, nxt_ff;
   logic signed [67:0] rx, rz;
   assign rx = (px_ff + 68'sd536870912) >>> 30;
   assign rz = (pz_ff + 68'sd536870912) >>> 30;
   always_ff @(posedge clock) begin
      if (reset) b_ff.vld <= 1'b0;
      else if (adv) b_ff.vld <= a_ff.vld;
      if (adv) begin
         b_ff.action <= a_ff.action; b_ff.ok <= a_ff.ok; b_ff.pole <= a_ff.pole;
         b_ff.ring <= a_ff.ring; b_ff.segment <= a_ff.segment;
         b_ff.slices <= a_ff.slices; b_ff.stacks <= a_ff.stacks; b_ff.diam <= a_ff.diam;
         tx_b_ff <= rx[33:0]; tz_b_ff <= rz[33:0]; ty_b_ff <= ty_a_ff;
         if (a_ff.pole[0]) num_b_ff <= '0;
         else if (a_ff.pole[1])
            num_b_ff <= 16'(16'd1 + ({7'd0, a_ff.stacks} - 16'd1) * {7'd0, a_ff.slices});
         else num_b_ff <= 16'(num_a_ff + 16'd1 + {8'd0, a_ff.segment});
         bb_ff  <= base_a_ff + 16'd1;
         i0_ff  <= num_a_ff + 16'd1;
         i1_ff  <= num_a_ff + {7'd0, a_ff.slices} + 16'd1;
         nxt_ff <= ({1'b0, a_ff.segment} + 9'd1 == a_ff.slices) ? 16'd0 :
                   {8'd0, a_ff.segment} + 16'd1;
      end
   end

   // Stage C: scale and saturate, form response beats
   function automatic logic [15:0] pos_q(input logic signed [33:0] t,
                                         input logic [15:0] d);
      logic signed [51:0] p;
      p = (52'(t) * $signed({1'b0, d}) + 52'sd1073741824) >>> 31;
      if (p < -52'sd32768) return 16'h8000;
      if (p > 52'sd32767) return 16'h7FFF;
      return p[15:0];
   endfunction
   function automatic logic [15:0] norm_q(input logic signed [33:0] t);
      logic signed [33:0] n;
      n = (t + 34'sd32768) >>> 16;
      if (n < -34'sd16384) return 16'hC000;
      if (n > 34'sd16384) return 16'h4000;
      return n[15:0];
   endfunction

   rsp_type r0, r1;
   logic    two;
   logic [15:0] sg;
   assign sg = {8'd0, b_ff.segment};
   always_comb begin
      r0 = '0; r1 = '0; two = 1'b0;
      r0.last = 1'b1;
      if (!b_ff.ok) r0.kind = KIND_REJECT;
      else if (!b_ff.action) begin
         r0.kind = KIND_VERTEX;
         r0.vertex_number = num_b_ff;
         r0.pos_x = pos_q(tx_b_ff, b_ff.diam);
         r0.pos_y = pos_q(ty_b_ff, b_ff.diam);
         r0.pos_z = pos_q(tz_b_ff, b_ff.diam);
         r0.norm_x = norm_q(tx_b_ff);
         r0.norm_y = norm_q(ty_b_ff);
         r0.norm_z = norm_q(tz_b_ff);
      end else begin
         r0.kind = KIND_TRIANGLE;
         if (b_ff.ring == 9'd0) begin
            r0.corner_a = '0; r0.corner_b = nxt_ff + 16'd1; r0.corner_c = sg + 16'd1;
         end else if (b_ff.ring == b_ff.stacks - 9'd1) begin
            r0.corner_a = bb_ff + {7'd0, b_ff.slices};
            r0.corner_b = sg + bb_ff;
            r0.corner_c = nxt_ff + bb_ff;
         end else begin
            two = 1'b1;
            r0.last = 1'b0;
            r0.corner_a = i0_ff + sg; r0.corner_b = i0_ff + nxt_ff;
            r0.corner_c = i1_ff + sg;
            r1.kind = KIND_TRIANGLE; r1.last = 1'b1;
            r1.corner_a = i0_ff + nxt_ff; r1.corner_b = i1_ff + nxt_ff;
            r1.corner_c = i1_ff + sg;
         end
      end
   end

   // Output stage with a second-beat holding slot
   logic    out_vld_ff, pend_ff;
   rsp_type out_ff, pend_data_ff;
   assign out_busy = pend_ff || (out_vld_ff && !rsp_ready);
   assign adv = !out_busy;
   assign req_ready = adv;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else if (!out_vld_ff || rsp_ready) begin
         if (pend_ff) begin
            out_vld_ff <= 1'b1;
            out_ff <= pend_data_ff;
            pend_ff <= 1'b0;
         end else begin
            out_vld_ff <= b_ff.vld;
            out_ff <= r0;
            pend_ff <= b_ff.vld && two;
            pend_data_ff <= r1;
         end
      end
   end
endmodule
`default_nettype wire

@@ rtl/uvs_divider.sv @@
// Pipelined restoring divider: quotient of (num << 32) / den, one bit per stage.
`default_nettype none
module uvs_divider
   import uvs_pkg::*;
#(
   parameter int LAT = 33
) (
   input  wire logic        clock,
   input  wire logic        adv,
   input  wire logic [8:0]  num,
   input  wire logic [8:0]  den,
   output logic      [31:0] quo
);
   // Numerator has 9 bits shifted by 32: quotient bits above 31 are discarded
   // since num < den whenever it is used. Remainder stays below den.
   logic [9:0]  rem_ff [LAT];
   logic [31:0] q_ff   [LAT];
   logic [8:0]  d_ff   [LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < LAT; k++) begin
            logic [9:0] r_in;
            logic [9:0] prev;
            logic [31:0] qp;
            logic [8:0] dd;
            if (k == 0) begin
               prev = {1'b0, num};
               qp = '0;
               dd = den;
               r_in = prev;
            end else begin
               prev = rem_ff[k-1];
               qp = q_ff[k-1];
               dd = d_ff[k-1];
               r_in = {prev[8:0], 1'b0};
            end
            if (k == 0) begin
               rem_ff[k] <= (r_in >= {1'b0, dd}) ? r_in - {1'b0, dd} : r_in;
               q_ff[k] <= '0;
            end else if (r_in >= {1'b0, dd}) begin
               rem_ff[k] <= r_in - {1'b0, dd};
               q_ff[k] <= {qp[30:0], 1'b1};
            end else begin
               rem_ff[k] <= r_in;
               q_ff[k] <= {qp[30:0], 1'b0};
            end
            d_ff[k] <= dd;
         end
      end
   end

   assign quo = q_ff[LAT-1];
endmodule
`default_nettype wire

@@ rtl/uvs_cordic.sv @@
// Pipelined rotation-mode CORDIC giving sine and cosine of a turn fraction.
`default_nettype none
module uvs_cordic
   import uvs_pkg::*;
#(
   parameter int ITER = 16
) (
   input  wire logic               clock,
   input  wire logic               adv,
   input  wire logic [31:0]        angle,
   output logic signed [33:0]      sin_o,
   output logic signed [33:0]      cos_o
);
   logic signed [33:0] x_ff [ITER+1];
   logic signed [33:0] y_ff [ITER+1];
   logic signed [33:0] z_ff [ITER+1];
   logic [1:0]         q_ff [ITER+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= GAIN_Q30;
         y_ff[0] <= '0;
         z_ff[0] <= {4'd0, angle[29:0]};
         q_ff[0] <= angle[31:30];
         for (int i = 0; i < ITER; i++) begin
            if (!z_ff[i][33]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_turn(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_turn(i);
            end
            q_ff[i+1] <= q_ff[i];
         end
      end
   end

   always_comb begin
      case (q_ff[ITER])
         2'd0: begin cos_o = x_ff[ITER];  sin_o = y_ff[ITER];  end
         2'd1: begin cos_o = -y_ff[ITER]; sin_o = x_ff[ITER];  end
         2'd2: begin cos_o = -x_ff[ITER]; sin_o = -y_ff[ITER]; end
         default: begin cos_o = y_ff[ITER]; sin_o = -x_ff[ITER]; end
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/uvs_checker.sv @@
// Port-level checker for the UV sphere mesh generator, bound to the top level.
`default_nettype none
module uvs_checker
   import uvs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data,
   input wire logic    req_ready
);
   ap_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");
   ap_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.kind != 2'd3)
      else $error("bad kind");
   ap_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid && rsp_data.last &&
      rsp_data.kind == KIND_TRIANGLE)
      else $error("second triangle missing");
   ap_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_REJECT |-> rsp_data.last)
      else $error("reject not last");
   ap_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");
endmodule

bind uv_sphere_mesh_generator uvs_checker u_uvs_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_data(rsp_data), .req_ready(req_ready));
`default_nettype wire
